### sv/cfmj_pkg.sv
// Shared constants, types and filter tables of the CAN mailbox with J1939 decode.
package cfmj_pkg;

   // Default number of filter slots and the widest slot index the design allows.
   localparam int FILTER_SLOTS = 13;
   localparam int SLOT_IDX_W   = 5;

   // Identifier normalization and signal decode constants.
   localparam logic [28:0] STD_ID_MAX  = 29'h7FF;
   localparam int          FRAC_BITS   = 24;
   localparam logic [2:0]  MAX_BYTES   = 3'd4;

   // Request kinds.
   localparam logic REQ_STORE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // Register indexes of the configuration port.
   localparam logic REG_EXTENDED_IDS = 1'b0;

   // Filter lists: 11-bit identifiers and J1939 PGNs.
   localparam int STD_ENTRIES = 13;
   localparam int PGN_ENTRIES = 12;
   localparam logic [15:0] STD_LIST [STD_ENTRIES] = '{
      16'h0250, 16'h0251, 16'h0254, 16'h022D, 16'h0361, 16'h03B5, 16'h03EC,
      16'h0450, 16'h065F, 16'h06A0, 16'h06A5, 16'h06A6, 16'h06B5
   };
   localparam logic [15:0] PGN_LIST [PGN_ENTRIES] = '{
      16'hFEE9, 16'hFEC1, 16'hFEF1, 16'hFEE5, 16'hFEFC, 16'hF004,
      16'hF003, 16'hFEEF, 16'hFEF5, 16'hFE6C, 16'hFEEE, 16'hFD09
   };

   // Filter entry of a slot; slots past the end of a list hold zero and never match.
   function automatic logic [15:0] filter_entry(input logic ext, input logic [SLOT_IDX_W-1:0] j);
      logic [15:0] e;
      e = 16'h0000;
      if (ext) begin
         if (j < SLOT_IDX_W'(PGN_ENTRIES)) e = PGN_LIST[j[3:0]];
      end else begin
         if (j < SLOT_IDX_W'(STD_ENTRIES)) e = STD_LIST[j[3:0]];
      end
      return e;
   endfunction

   // Outcome of a slot search.
   typedef struct packed {
      logic                  hit;
      logic [SLOT_IDX_W-1:0] idx;
   } cfmj_hit_type;

   // One request word as held in the input register.
   typedef struct packed {
      logic        req_type;
      logic [28:0] frame_id;
      logic [31:0] data_low;
      logic [31:0] data_high;
      logic [15:0] pgn;
      logic [3:0]  start_byte;
      logic [2:0]  byte_count;
      logic [24:0] scale;
      logic [15:0] offset;
   } cfmj_req_type;

   // Extracted signal waiting for scaling.
   typedef struct packed {
      logic        matched;
      logic [3:0]  slot_index;
      logic        not_available;
      logic        calc;
      logic [31:0] raw;
      logic [24:0] scale;
      logic [15:0] offset;
   } cfmj_ext_type;

   // One response word.
   typedef struct packed {
      logic        matched;
      logic [3:0]  slot_index;
      logic        not_available;
      logic [63:0] signal_value;
   } cfmj_rsp_type;

endpackage

### sv/cfmj_if.sv
// Request and response channel interfaces of the CAN mailbox.
interface cfmj_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [28:0] frame_id;
   logic [31:0] data_low;
   logic [31:0] data_high;
   logic [15:0] pgn;
   logic [3:0]  start_byte;
   logic [2:0]  byte_count;
   logic [24:0] scale;
   logic signed [15:0] offset;

   modport source (output valid, req_type, frame_id, data_low, data_high, pgn,
                   start_byte, byte_count, scale, offset, input ready);
   modport sink   (input valid, req_type, frame_id, data_low, data_high, pgn,
                   start_byte, byte_count, scale, offset, output ready);
endinterface

interface cfmj_rsp_if;
   logic        valid;
   logic        ready;
   logic        matched;
   logic [3:0]  slot_index;
   logic        not_available;
   logic signed [63:0] signal_value;

   modport source (output valid, matched, slot_index, not_available, signal_value,
                   input ready);
   modport sink   (input valid, matched, slot_index, not_available, signal_value,
                   output ready);
endinterface

### sv/can_id_filter_mailbox_j1939_signal.sv
// Top level: CAN latest-value mailbox with J1939 signal extraction and scaling.
// Pipeline: a word accepted into the input register moves on to the extract register
// and then to the output register, which holds its response until it is taken.
// Throughput: one word per cycle; output back-pressure ripples back to req ready,
// and the 32 by 25 bit multiply-add in front of the output register is the longest path.
// Reset (synchronous, active high) clears all slot valid bits, the pipeline and
// extended_ids; slot payloads are not cleared and are read only once valid.
module can_id_filter_mailbox_j1939_signal #(
   parameter int FILTER_SLOTS = cfmj_pkg::FILTER_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   cfmj_req_if.sink    req_ch,
   cfmj_rsp_if.source  rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                   ext_ids_ff;
   logic                   s0_valid_ff;
   cfmj_pkg::cfmj_req_type s0_ff;
   logic                   s1_valid_ff;
   cfmj_pkg::cfmj_ext_type s1_ff;
   cfmj_pkg::cfmj_ext_type s1_in;
   logic                   s2_valid_ff;
   cfmj_pkg::cfmj_rsp_type s2_ff;
   cfmj_pkg::cfmj_rsp_type s2_in;
   logic                   s2_free;
   logic                   s1_free;
   logic                   s0_free;
   logic                   s0_move;
   logic                   s1_move;
   logic [15:0]            s0_key;
   logic [63:0]            s0_data;
   cfmj_pkg::cfmj_hit_type filt_hit;
   cfmj_pkg::cfmj_hit_type read_hit;
   logic [63:0]            read_data;
   logic [2:0]             count_eff;
   logic [31:0]            raw;
   logic [31:0]            ones;
   logic [56:0]            product;
   logic [63:0]            off_term;

   // Configuration port: single register, writes complete in the access phase.
   assign pready = 1'b1;
   assign prdata = (paddr[2] == cfmj_pkg::REG_EXTENDED_IDS) ? {31'b0, ext_ids_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ids_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready &&
                   (paddr[2] == cfmj_pkg::REG_EXTENDED_IDS)) begin
         ext_ids_ff <= pwdata[0];
      end
   end

   // Pipeline flow: each stage advances when the one after it has room.
   assign s2_free = !s2_valid_ff || rsp_ch.ready;
   assign s1_move = s1_valid_ff && s2_free;
   assign s1_free = !s1_valid_ff || s2_free;
   assign s0_move = s0_valid_ff && s1_free;
   assign s0_free = !s0_valid_ff || s1_free;
   assign req_ch.ready = s0_free;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_free) begin
         s0_valid_ff <= req_ch.valid;
      end
      if (s0_free && req_ch.valid) begin
         s0_ff.req_type   <= req_ch.req_type;
         s0_ff.frame_id   <= req_ch.frame_id;
         s0_ff.data_low   <= req_ch.data_low;
         s0_ff.data_high  <= req_ch.data_high;
         s0_ff.pgn        <= req_ch.pgn;
         s0_ff.start_byte <= req_ch.start_byte;
         s0_ff.byte_count <= req_ch.byte_count;
         s0_ff.scale      <= req_ch.scale;
         s0_ff.offset     <= req_ch.offset;
      end
   end

   // Identifier normalization: extended identifiers give their PGN field.
   assign s0_key  = (s0_ff.frame_id > cfmj_pkg::STD_ID_MAX) ? s0_ff.frame_id[23:8]
                                                             : {5'b0, s0_ff.frame_id[10:0]};
   assign s0_data = {s0_ff.data_high, s0_ff.data_low};

   cfmj_mailbox #(
      .FILTER_SLOTS(FILTER_SLOTS)
   ) u_mailbox (
      .clock      (clock),
      .reset      (reset),
      .ext_ids    (ext_ids_ff),
      .store_en   (s0_move && (s0_ff.req_type == cfmj_pkg::REQ_STORE)),
      .store_key  (s0_key),
      .store_data (s0_data),
      .read_key   (s0_ff.pgn),
      .filt_hit   (filt_hit),
      .read_hit   (read_hit),
      .read_data  (read_data)
   );

   // Little-endian byte pick; positions outside bytes 1 to 8 read as zero.
   assign count_eff = (s0_ff.byte_count > cfmj_pkg::MAX_BYTES) ? cfmj_pkg::MAX_BYTES
                                                                : s0_ff.byte_count;
   always_comb begin
      raw  = '0;
      ones = '0;
      for (int i = 0; i < 4; i++) begin
         logic [4:0] pos;
         logic [2:0] sel;
         pos = {1'b0, s0_ff.start_byte} + 5'(i);
         sel = 3'(pos - 5'd1);
         if (3'(i) < count_eff) begin
            ones[i*8 +: 8] = 8'hFF;
            if ((pos >= 5'd1) && (pos <= 5'd8)) begin
               raw[i*8 +: 8] = read_data[sel*8 +: 8];
            end
         end
      end
   end

   // Extract stage result: store reports the filter outcome, read the lookup.
   always_comb begin
      s1_in = '0;
      s1_in.raw    = raw;
      s1_in.scale  = s0_ff.scale;
      s1_in.offset = s0_ff.offset;
      if (s0_ff.req_type == cfmj_pkg::REQ_STORE) begin
         s1_in.matched    = filt_hit.hit;
         s1_in.slot_index = filt_hit.idx[3:0];
      end else if (read_hit.hit) begin
         s1_in.matched       = 1'b1;
         s1_in.slot_index    = read_hit.idx[3:0];
         s1_in.not_available = (raw == ones);
         s1_in.calc          = (raw != ones);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= s0_valid_ff;
      end
      if (s0_move) begin
         s1_ff <= s1_in;
      end
   end

   // Scaling: raw times resolution plus the whole-number offset in Q.24.
   assign product  = 57'(s1_ff.raw) * 57'(s1_ff.scale);
   assign off_term = {{(64 - 16 - cfmj_pkg::FRAC_BITS){s1_ff.offset[15]}}, s1_ff.offset,
                      {cfmj_pkg::FRAC_BITS{1'b0}}};

   always_comb begin
      s2_in.matched       = s1_ff.matched;
      s2_in.slot_index    = s1_ff.slot_index;
      s2_in.not_available = s1_ff.not_available;
      s2_in.signal_value  = s1_ff.calc ? (64'(product) + off_term) : 64'b0;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s1_move) begin
         s2_ff <= s2_in;
      end
   end

   assign rsp_ch.valid         = s2_valid_ff;
   assign rsp_ch.matched       = s2_ff.matched;
   assign rsp_ch.slot_index    = s2_ff.slot_index;
   assign rsp_ch.not_available = s2_ff.not_available;
   assign rsp_ch.signal_value  = s2_ff.signal_value;

   // A word waiting in the extract register is not lost while the output stalls.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_free) |=> s1_valid_ff)
      else $error("extract stage dropped a word under stall");

   // Not available forces a zero value and implies a found frame.
   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_ff.not_available) |->
      (s2_ff.matched && (s2_ff.signal_value == 64'b0)))
      else $error("not-available response carries a value");

   // A miss reports slot zero and no value.
   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_ff.matched) |->
      ((s2_ff.slot_index == 4'd0) && (s2_ff.signal_value == 64'b0)))
      else $error("miss response carries a slot or value");

   // Scaling is only requested for a read that found a frame.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.calc) |-> (s1_ff.matched && !s1_ff.not_available))
      else $error("scaling enabled without a found frame");

endmodule

### sv/cfmj_mailbox.sv
// Slot store of the mailbox: filter match, payload slots and lookup by identifier.
module cfmj_mailbox #(
   parameter int FILTER_SLOTS = cfmj_pkg::FILTER_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   ext_ids,
   input  logic                   store_en,
   input  logic [15:0]            store_key,
   input  logic [63:0]            store_data,
   input  logic [15:0]            read_key,
   output cfmj_pkg::cfmj_hit_type filt_hit,
   output cfmj_pkg::cfmj_hit_type read_hit,
   output logic [63:0]            read_data
);

   localparam int SLOT_W = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;

   logic [FILTER_SLOTS-1:0] slot_valid_ff;
   logic [15:0]             slot_key_ff [FILTER_SLOTS];
   logic [63:0]             slot_data_ff [FILTER_SLOTS];
   logic                    write_en;
   logic [SLOT_W-1:0]       write_slot;
   logic [SLOT_W-1:0]       read_slot;

   // First filter entry equal to the key; walking down lets the lowest slot win.
   always_comb begin
      filt_hit = '0;
      for (int j = FILTER_SLOTS - 1; j >= 0; j--) begin
         logic [15:0] e;
         e = cfmj_pkg::filter_entry(ext_ids, cfmj_pkg::SLOT_IDX_W'(j));
         if ((e != 16'h0000) && (e == store_key)) begin
            filt_hit.hit = 1'b1;
            filt_hit.idx = cfmj_pkg::SLOT_IDX_W'(j);
         end
      end
   end

   // First valid slot that holds the requested identifier.
   always_comb begin
      read_hit = '0;
      for (int j = FILTER_SLOTS - 1; j >= 0; j--) begin
         if (slot_valid_ff[j] && (slot_key_ff[j] == read_key)) begin
            read_hit.hit = 1'b1;
            read_hit.idx = cfmj_pkg::SLOT_IDX_W'(j);
         end
      end
   end

   assign write_en   = store_en && filt_hit.hit;
   assign write_slot = filt_hit.idx[SLOT_W-1:0];
   assign read_slot  = read_hit.idx[SLOT_W-1:0];
   assign read_data  = slot_data_ff[read_slot];

   // Valid bits are cleared by reset; a slot becomes valid on its first store.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (write_en) begin
         slot_valid_ff[write_slot] <= 1'b1;
      end
   end

   // Key and payload of the latest frame in each slot.
   always_ff @(posedge clock) begin
      if (write_en) begin
         slot_key_ff[write_slot]  <= store_key;
         slot_data_ff[write_slot] <= store_data;
      end
   end

   // A hit only ever names a slot that exists.
   assert property (@(posedge clock) disable iff (reset)
      filt_hit.hit |-> (int'(filt_hit.idx) < FILTER_SLOTS))
      else $error("filter hit names a slot past the table");

   // A stored frame is visible in its slot on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      write_en |=> slot_valid_ff[$past(write_slot)])
      else $error("stored slot not marked valid");

   // Lookup never reports a slot that was never written.
   assert property (@(posedge clock) disable iff (reset)
      read_hit.hit |-> slot_valid_ff[read_slot])
      else $error("lookup hit on an empty slot");

endmodule

### test/can_id_filter_mailbox_j1939_signal_tb.sv
// Self-checking testbench for the CAN mailbox with J1939 signal decode.
module can_id_filter_mailbox_j1939_signal_tb;

   localparam int LIMIT_CYCLES = 200000;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   cfmj_req_if req_bus ();
   cfmj_rsp_if rsp_bus ();

   can_id_filter_mailbox_j1939_signal u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Words waiting to be offered, and the responses predicted for accepted words.
   cfmj_pkg::cfmj_req_type request_q[$];
   cfmj_pkg::cfmj_rsp_type outcome_q[$];
   cfmj_pkg::cfmj_req_type on_bus;
   cfmj_pkg::cfmj_rsp_type head_word;

   // Shadow of the mailbox: list selection and the contents of every slot.
   logic        ext_mode;
   logic        slot_full [cfmj_pkg::FILTER_SLOTS];
   logic [15:0] slot_id   [cfmj_pkg::FILTER_SLOTS];
   logic [63:0] slot_data [cfmj_pkg::FILTER_SLOTS];

   int send_gap_pct;
   int take_gap_pct;
   int fail_count;
   int cycle_count;
   int stores_sent;
   int reads_sent;
   int hits_seen;
   int na_seen;

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string what);
      fail_count++;
      $display("[%0d] mismatch: %s", cycle_count, what);
   endtask

   // Predicts the response to one word and updates the shadow slots.
   function automatic cfmj_pkg::cfmj_rsp_type mailbox_outcome(
      input cfmj_pkg::cfmj_req_type w);
      cfmj_pkg::cfmj_rsp_type r;
      logic [15:0]  key;
      logic [15:0]  entry;
      logic [63:0]  raw;
      logic [63:0]  ones;
      logic [63:0]  bias;
      int           slot;
      int           j;
      int           i;
      int           pos;
      int           nbytes;
      r = '0;
      slot = -1;
      if (w.req_type == cfmj_pkg::REQ_STORE) begin
         // Long identifiers carry the PGN in bits 23:8, short ones keep 11 bits.
         if (w.frame_id > cfmj_pkg::STD_ID_MAX) key = w.frame_id[23:8];
         else key = {5'b0, w.frame_id[10:0]};
         for (j = 0; j < cfmj_pkg::FILTER_SLOTS; j++) begin
            if (ext_mode)
               entry = (j < cfmj_pkg::PGN_ENTRIES) ? cfmj_pkg::PGN_LIST[j] : 16'h0000;
            else
               entry = (j < cfmj_pkg::STD_ENTRIES) ? cfmj_pkg::STD_LIST[j] : 16'h0000;
            if (slot < 0 && entry != 16'h0000 && entry == key) slot = j;
         end
         if (slot >= 0) begin
            slot_data[slot] = {w.data_high, w.data_low};
            slot_id[slot]   = key;
            slot_full[slot] = 1'b1;
            r.matched       = 1'b1;
            r.slot_index    = 4'(slot);
         end
      end else begin
         // Lookup goes by the identifier held in each slot, not the current list.
         for (j = 0; j < cfmj_pkg::FILTER_SLOTS; j++) begin
            if (slot < 0 && slot_full[j] && slot_id[j] == w.pgn) slot = j;
         end
         if (slot >= 0) begin
            r.matched    = 1'b1;
            r.slot_index = 4'(slot);
            nbytes = (w.byte_count > cfmj_pkg::MAX_BYTES) ? int'(cfmj_pkg::MAX_BYTES)
                                                          : int'(w.byte_count);
            raw  = '0;
            ones = '0;
            for (i = 0; i < nbytes; i++) begin
               pos = int'(w.start_byte) + i;
               if (pos >= 1 && pos <= 8) begin
                  raw |= ((slot_data[slot] >> (8 * (pos - 1))) & 64'hFF) << (8 * i);
               end
               ones |= 64'hFF << (8 * i);
            end
            if (raw == ones) begin
               r.not_available = 1'b1;
            end else begin
               bias = {{48{w.offset[15]}}, w.offset} << cfmj_pkg::FRAC_BITS;
               r.signal_value = raw * 64'(w.scale) + bias;
            end
         end
      end
      return r;
   endfunction

   // One entry of either filter list.
   function automatic logic [15:0] pick_key(input logic from_pgn);
      if (from_pgn) return cfmj_pkg::PGN_LIST[$urandom_range(cfmj_pkg::PGN_ENTRIES - 1)];
      return cfmj_pkg::STD_LIST[$urandom_range(cfmj_pkg::STD_ENTRIES - 1)];
   endfunction

   // Four payload bytes, with all-ones bytes frequent enough to hit not-available.
   function automatic logic [31:0] random_lanes();
      logic [31:0] v;
      int          b;
      v = $urandom;
      for (b = 0; b < 4; b++) begin
         if ($urandom_range(99) < 35) v[8*b +: 8] = 8'hFF;
      end
      return v;
   endfunction

   // Mostly well-formed stores and reads against the lists, the rest noise.
   function automatic cfmj_pkg::cfmj_req_type random_word();
      cfmj_pkg::cfmj_req_type w;
      logic [15:0]  pick;
      int           roll;
      w.req_type   = cfmj_pkg::REQ_READ;
      w.frame_id   = 29'($urandom);
      w.data_low   = random_lanes();
      w.data_high  = random_lanes();
      w.pgn        = 16'($urandom);
      w.start_byte = 4'($urandom);
      w.byte_count = 3'($urandom);
      w.scale      = 25'($urandom);
      w.offset     = 16'($urandom);
      if ($urandom_range(99) < 45) begin
         w.req_type = cfmj_pkg::REQ_STORE;
         pick = pick_key(ext_mode);
         roll = $urandom_range(99);
         if (roll < 75) begin
            if (ext_mode || roll < 20) w.frame_id = {5'($urandom), pick, 8'($urandom)};
            else w.frame_id = 29'(pick[10:0]);
         end else if (roll < 85) begin
            w.frame_id = 29'($urandom_range(12'h7FF));
         end
      end else begin
         roll = $urandom_range(99);
         if (roll < 75) w.pgn = pick_key(ext_mode);
         else if (roll < 88) w.pgn = pick_key(!ext_mode);
         if ($urandom_range(99) < 85) w.start_byte = 4'($urandom_range(8, 1));
         if ($urandom_range(99) < 85) w.byte_count = 3'($urandom_range(4, 1));
         roll = $urandom_range(99);
         if (roll < 10) w.scale = '0;
         else if (roll < 20) w.scale = '1;
      end
      return w;
   endfunction

   task automatic queue_store(input logic [28:0] id, input logic [31:0] lo,
                              input logic [31:0] hi);
      cfmj_pkg::cfmj_req_type w;
      w = '0;
      w.req_type  = cfmj_pkg::REQ_STORE;
      w.frame_id  = id;
      w.data_low  = lo;
      w.data_high = hi;
      request_q.push_back(w);
   endtask

   task automatic queue_read(input logic [15:0] key, input logic [3:0] first,
                             input logic [2:0] count, input logic [24:0] scale,
                             input logic [15:0] offset);
      cfmj_pkg::cfmj_req_type w;
      w = '0;
      w.req_type   = cfmj_pkg::REQ_READ;
      w.pgn        = key;
      w.start_byte = first;
      w.byte_count = count;
      w.scale      = scale;
      w.offset     = offset;
      request_q.push_back(w);
   endtask

   // Block until every queued word is accepted and every response has come back.
   task automatic drain();
      while (request_q.size() != 0 || req_bus.valid || outcome_q.size() != 0)
         @(posedge clock);
   endtask

   // Register write followed by a read back of the same register.
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == 3'(4 * cfmj_pkg::REG_EXTENDED_IDS)) ext_mode = value[0];
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== {31'b0, value[0]})
         report_mismatch($sformatf("register read back %h, wrote %h", prdata, value));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, outcome_q.size());
         $display("can_id_filter_mailbox_j1939_signal_tb: FAIL");
         $finish;
      end
   end

   // Request driver: offers queued words with random gaps and predicts each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            outcome_q.push_back(mailbox_outcome(on_bus));
            if (on_bus.req_type == cfmj_pkg::REQ_STORE) stores_sent++;
            else reads_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               on_bus = request_q.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.req_type   <= on_bus.req_type;
               req_bus.frame_id   <= on_bus.frame_id;
               req_bus.data_low   <= on_bus.data_low;
               req_bus.data_high  <= on_bus.data_high;
               req_bus.pgn        <= on_bus.pgn;
               req_bus.start_byte <= on_bus.start_byte;
               req_bus.byte_count <= on_bus.byte_count;
               req_bus.scale      <= on_bus.scale;
               req_bus.offset     <= on_bus.offset;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: random back-pressure and in-order comparison per field.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (outcome_q.size() == 0) begin
               report_mismatch($sformatf("unexpected response word matched=%b slot=%0d",
                                         rsp_bus.matched, rsp_bus.slot_index));
            end else begin
               head_word = outcome_q.pop_front();
               if (rsp_bus.matched !== head_word.matched)
                  report_mismatch($sformatf("matched %b, expected %b",
                                            rsp_bus.matched, head_word.matched));
               if (rsp_bus.slot_index !== head_word.slot_index)
                  report_mismatch($sformatf("slot_index %0d, expected %0d",
                                            rsp_bus.slot_index, head_word.slot_index));
               if (rsp_bus.not_available !== head_word.not_available)
                  report_mismatch($sformatf("not_available %b, expected %b",
                                            rsp_bus.not_available,
                                            head_word.not_available));
               if (rsp_bus.signal_value !== head_word.signal_value)
                  report_mismatch($sformatf("signal_value %h, expected %h",
                                            rsp_bus.signal_value,
                                            head_word.signal_value));
               if (head_word.matched) hits_seen++;
               if (head_word.not_available) na_seen++;
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= take_gap_pct);
      end
   end

   // Stimulus sequence.
   initial begin
      int n;
      reset              = 1'b1;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = cfmj_pkg::REQ_STORE;
      req_bus.frame_id   = '0;
      req_bus.data_low   = '0;
      req_bus.data_high  = '0;
      req_bus.pgn        = '0;
      req_bus.start_byte = '0;
      req_bus.byte_count = '0;
      req_bus.scale      = '0;
      req_bus.offset     = '0;
      rsp_bus.ready      = 1'b0;
      ext_mode           = 1'b0;
      send_gap_pct       = 11;
      take_gap_pct       = 52;
      fail_count         = 0;
      cycle_count        = 0;
      stores_sent        = 0;
      reads_sent         = 0;
      hits_seen          = 0;
      na_seen            = 0;
      for (n = 0; n < cfmj_pkg::FILTER_SLOTS; n++) begin
         slot_full[n] = 1'b0;
         slot_id[n]   = '0;
         slot_data[n] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      csr_write(3'(4 * cfmj_pkg::REG_EXTENDED_IDS), 32'd0);

      // Directed words on the 11-bit list: empty mailbox, boundaries, byte windows.
      queue_read(16'h0250, 4'd1, 3'd1, 25'h1000000, 16'h0000);
      queue_store(29'h250, 32'h44332211, 32'h88776655);
      queue_store(29'h7FF, 32'h12345678, 32'h9ABCDEF0);
      queue_store(29'h800, 32'hFFFFFFFF, 32'hFFFFFFFF);
      queue_store(29'h1FFFFFFF, 32'h00000000, 32'h00000000);
      // A long identifier whose middle bits equal an 11-bit list entry.
      queue_store({5'h00, 16'h06B5, 8'h11}, 32'hFFFFFFFF, 32'hFF00FFFF);
      queue_read(16'h0250, 4'd1, 3'd4, 25'h1000000, 16'h0000);
      queue_read(16'h0250, 4'd5, 3'd4, 25'h1FFFFFF, 16'h7FFF);
      queue_read(16'h0250, 4'd7, 3'd4, 25'h1000000, 16'h8000);
      queue_read(16'h0250, 4'd0, 3'd2, 25'h0000001, 16'h0001);
      queue_read(16'h0250, 4'd15, 3'd1, 25'h1FFFFFF, 16'hFFFF);
      queue_read(16'h0250, 4'd2, 3'd0, 25'h1000000, 16'h1234);
      queue_read(16'h0250, 4'd1, 3'd7, 25'h0000000, 16'h8000);
      queue_read(16'h06B5, 4'd1, 3'd4, 25'h1000000, 16'h0005);
      queue_read(16'h06B5, 4'd6, 3'd3, 25'h0800000, 16'hFFF0);
      queue_read(16'h0000, 4'd1, 3'd1, 25'h1000000, 16'h0000);
      drain();

      // Directed words on the PGN list; slots from the 11-bit list stay readable.
      csr_write(3'(4 * cfmj_pkg::REG_EXTENDED_IDS), 32'd1);
      queue_store({5'h18, 16'hFEE9, 8'h00}, 32'hA5A5A5A5, 32'h5A5A5A5A);
      queue_store({5'h1F, 16'hFD09, 8'hFF}, 32'h00FF00FF, 32'hFFFFFF01);
      queue_store(29'h250, 32'h11111111, 32'h22222222);
      queue_read(16'h06B5, 4'd6, 3'd3, 25'h1000000, 16'h0000);
      queue_read(16'hFEE9, 4'd3, 3'd2, 25'h0ABCDEF, 16'hFFFF);
      queue_read(16'hFD09, 4'd8, 3'd4, 25'h1FFFFFF, 16'h7FFF);
      queue_read(16'h0250, 4'd1, 3'd4, 25'h1000000, 16'h0000);
      drain();

      // PGN list, light sender gaps and heavy back-pressure, in two batches with a full drain after each.
      for (n = 0; n < 225; n++) request_q.push_back(random_word());
      drain();
      for (n = 0; n < 225; n++) request_q.push_back(random_word());
      drain();

      // 11-bit list, heavy sender gaps and light back-pressure.
      csr_write(3'(4 * cfmj_pkg::REG_EXTENDED_IDS), 32'd0);
      send_gap_pct = 52;
      take_gap_pct = 11;
      for (n = 0; n < 450; n++) request_q.push_back(random_word());
      drain();

      // PGN list again at full rate.
      csr_write(3'(4 * cfmj_pkg::REG_EXTENDED_IDS), 32'd1);
      send_gap_pct = 0;
      take_gap_pct = 0;
      for (n = 0; n < 500; n++) request_q.push_back(random_word());
      drain();

      repeat (8) @(posedge clock);
      if (outcome_q.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", outcome_q.size()));
      $display("Ran %0d store and %0d read words on both filter lists and three pacing mixes.",
               stores_sent, reads_sent);
      $display("%0d responses reported a match and %0d reads came back not available.",
               hits_seen, na_seen);
      if (fail_count == 0) begin
         $display("can_id_filter_mailbox_j1939_signal_tb: PASS");
      end else begin
         $display("can_id_filter_mailbox_j1939_signal_tb: FAIL");
      end
      $finish;
   end

endmodule

### can_id_filter_mailbox_j1939_signal.f
sv/cfmj_pkg.sv
sv/cfmj_if.sv
sv/cfmj_mailbox.sv
sv/can_id_filter_mailbox_j1939_signal.sv
test/can_id_filter_mailbox_j1939_signal_tb.sv
